>>> rtl/core/phtp_pkg.sv
// Shared types, constants and helpers for the print head halftone packer.
`default_nettype none
package phtp_pkg;

	localparam int MAX_REPEAT_DEF = 16;
	localparam int RESULT_CAP     = 16;
	localparam int REP_W          = 5;
	localparam int COL_W          = 16;
	localparam int ROW_W          = 16;
	localparam int CFG_AW         = 5;
	localparam int CFG_DW         = 32;

	// floor(row / 24) == (row * DIV24_MUL) >> DIV24_SHIFT for any 16-bit row
	localparam logic [15:0] DIV24_MUL   = 16'd43691;
	localparam int          DIV24_SHIFT = 20;

	localparam logic [5:0] PIN_TABLE [6] = '{6'd32, 6'd16, 6'd8, 6'd4, 6'd2, 6'd1};

	typedef enum logic [2:0] {
		REG_THRESHOLD   = 3'd0,
		REG_COLOR_MODE  = 3'd1,
		REG_HIGH_VRES   = 3'd2,
		REG_DITHER_ROW0 = 3'd3,
		REG_DITHER_ROW1 = 3'd4,
		REG_DITHER_ROW2 = 3'd5,
		REG_DITHER_ROW3 = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [3:0]       threshold;
		logic             color_mode;
		logic             high_vres;
		logic [3:0][31:0] dither_rows;
	} cfg_t;

	typedef struct packed {
		logic load_row;
		logic mul_row;
		logic load_geom;
		logic load_pix;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic last_rep;
	} dp_status_t;

	typedef struct packed {
		logic [5:0] pin;
		logic [1:0] lane;
	} geom_t;

	// row mod 24 -> pin bit and byte lane
	function automatic geom_t row_geom(input logic [4:0] m24);
		geom_t      g;
		logic [4:0] m6;
		if (m24 >= 5'd18) begin
			g.lane = 2'd3;
			m6     = m24 - 5'd18;
		end else if (m24 >= 5'd12) begin
			g.lane = 2'd2;
			m6     = m24 - 5'd12;
		end else if (m24 >= 5'd6) begin
			g.lane = 2'd1;
			m6     = m24 - 5'd6;
		end else begin
			g.lane = 2'd0;
			m6     = m24;
		end
		g.pin = (m6 < 5'd6) ? PIN_TABLE[m6[2:0]] : PIN_TABLE[0];
		return g;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/phtp_regs.sv
// APB configuration registers of the halftone packer.
`default_nettype none
module phtp_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [phtp_pkg::CFG_AW-1:0]   paddr,
	input  wire logic [phtp_pkg::CFG_DW-1:0]   pwdata,
	output logic      [phtp_pkg::CFG_DW-1:0]   prdata,
	output logic                               pready,
	output phtp_pkg::cfg_t                     cfg
);

	phtp_pkg::cfg_t     cfg_q;
	phtp_pkg::reg_idx_t idx;
	logic               wr_en;

	assign pready = 1'b1;
	assign idx    = phtp_pkg::reg_idx_t'(paddr[phtp_pkg::CFG_AW-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				phtp_pkg::REG_THRESHOLD:   cfg_q.threshold      <= pwdata[3:0];
				phtp_pkg::REG_COLOR_MODE:  cfg_q.color_mode     <= pwdata[0];
				phtp_pkg::REG_HIGH_VRES:   cfg_q.high_vres      <= pwdata[0];
				phtp_pkg::REG_DITHER_ROW0: cfg_q.dither_rows[0] <= pwdata;
				phtp_pkg::REG_DITHER_ROW1: cfg_q.dither_rows[1] <= pwdata;
				phtp_pkg::REG_DITHER_ROW2: cfg_q.dither_rows[2] <= pwdata;
				phtp_pkg::REG_DITHER_ROW3: cfg_q.dither_rows[3] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			phtp_pkg::REG_THRESHOLD:   prdata = {28'd0, cfg_q.threshold};
			phtp_pkg::REG_COLOR_MODE:  prdata = {31'd0, cfg_q.color_mode};
			phtp_pkg::REG_HIGH_VRES:   prdata = {31'd0, cfg_q.high_vres};
			phtp_pkg::REG_DITHER_ROW0: prdata = cfg_q.dither_rows[0];
			phtp_pkg::REG_DITHER_ROW1: prdata = cfg_q.dither_rows[1];
			phtp_pkg::REG_DITHER_ROW2: prdata = cfg_q.dither_rows[2];
			phtp_pkg::REG_DITHER_ROW3: prdata = cfg_q.dither_rows[3];
			default:                   prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/core/phtp_ctrl.sv
// Sequencer for row-start and pixel requests of the halftone packer.
`default_nettype none
module phtp_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 src_valid,
	input  wire logic                 action,
	output logic                      src_stall,
	input  wire phtp_pkg::dp_status_t status,
	output phtp_pkg::ctrl_cmd_t       cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROW_MUL,
		ST_ROW_SET,
		ST_RUN
	} state_t;

	state_t state_q;
	logic   stall_q;
	logic   accept;

	assign src_stall = stall_q;
	assign accept    = src_valid && !stall_q;

	always_comb begin
		cmd           = '0;
		cmd.load_row  = (state_q == ST_IDLE) && accept && !action;
		cmd.load_pix  = (state_q == ST_IDLE) && accept && action;
		cmd.mul_row   = (state_q == ST_ROW_MUL);
		cmd.load_geom = (state_q == ST_ROW_SET);
		cmd.emit      = (state_q == ST_RUN) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stall_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= action ? ST_RUN : ST_ROW_MUL;
						stall_q <= 1'b1;
					end
				end
				ST_ROW_MUL: begin
					state_q <= ST_ROW_SET;
				end
				ST_ROW_SET: begin
					state_q <= ST_IDLE;
					stall_q <= 1'b0;
				end
				ST_RUN: begin
					if (status.out_free && status.last_rep) begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> stall_q)
		else $error("request taken while busy");
	a_run_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && status.out_free && status.last_rep) |=> (state_q == ST_IDLE))
		else $error("run did not end after final column");
	a_row_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_row |=> (state_q == ST_ROW_MUL) ##1 (state_q == ST_ROW_SET))
		else $error("row setup sequence broken");

endmodule
`default_nettype wire

>>> rtl/core/phtp_dp.sv
// Datapath: row geometry, column and repeat counters, dither compare, result register.
`default_nettype none
module phtp_dp #(
	parameter int MAX_REPEAT = phtp_pkg::MAX_REPEAT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire phtp_pkg::cfg_t                cfg,
	input  wire phtp_pkg::ctrl_cmd_t           cmd,
	output phtp_pkg::dp_status_t               status,
	input  wire logic [phtp_pkg::ROW_W-1:0]    row_number,
	input  wire logic [phtp_pkg::COL_W-1:0]    start_column,
	input  wire logic [7:0]                    black,
	input  wire logic [7:0]                    yellow,
	input  wire logic [7:0]                    magenta,
	input  wire logic [7:0]                    cyan,
	input  wire logic [phtp_pkg::REP_W-1:0]    repeat_req,
	input  wire logic                          res_stall,
	output logic                               res_valid,
	output logic      [phtp_pkg::COL_W-1:0]    column,
	output logic      [1:0]                    byte_lane,
	output logic      [5:0]                    bit_mask,
	output logic                               second_half,
	output logic                               set_black,
	output logic                               set_yellow,
	output logic                               set_magenta,
	output logic                               set_cyan,
	output logic                               last_of_run
);

	localparam int CAP_RAW = (MAX_REPEAT < phtp_pkg::RESULT_CAP) ? MAX_REPEAT
		: phtp_pkg::RESULT_CAP;
	localparam int CAP = (CAP_RAW < 1) ? 1 : CAP_RAW;
	localparam logic [phtp_pkg::REP_W-1:0] CAP_V = phtp_pkg::REP_W'(CAP);

	// geometry and counters
	logic [phtp_pkg::ROW_W-1:0] row_q;
	logic [11:0]                quot_q;
	logic [phtp_pkg::COL_W-1:0] col_q;
	logic [5:0]                 pin_q;
	logic [1:0]                 lane_q;
	logic                       half_q;
	logic [1:0]                 drow_q;
	logic [phtp_pkg::REP_W-1:0] rep_q;
	logic [7:0]                 bk_q, ye_q, ma_q, cy_q;

	// result register
	logic                       res_valid_q;
	logic [phtp_pkg::COL_W-1:0] column_q;
	logic [1:0]                 lane_out_q;
	logic [5:0]                 mask_q;
	logic                       half_out_q;
	logic                       sb_q, sy_q, sm_q, sc_q, last_q;

	logic [phtp_pkg::ROW_W-1:0] row_h;
	logic [31:0]                prod;
	logic [phtp_pkg::ROW_W-1:0] q24;
	logic [phtp_pkg::ROW_W-1:0] m24_full;
	phtp_pkg::geom_t            geom;
	logic [phtp_pkg::REP_W-1:0] rep_in;
	logic [31:0]                dword;
	logic [7:0]                 dent;
	logic                       sb, sy, sm, sc;

	assign row_h    = cfg.high_vres ? {1'b0, row_number[phtp_pkg::ROW_W-1:1]} : row_number;
	assign prod     = row_q * phtp_pkg::DIV24_MUL;
	assign q24      = phtp_pkg::ROW_W'({quot_q, 4'b0}) + phtp_pkg::ROW_W'({quot_q, 3'b0});
	assign m24_full = row_q - q24;
	assign geom     = phtp_pkg::row_geom(m24_full[4:0]);

	always_comb begin
		rep_in = (repeat_req == '0) ? phtp_pkg::REP_W'(1) : repeat_req;
		if (rep_in > CAP_V)
			rep_in = CAP_V;
	end

	assign dword = cfg.dither_rows[drow_q];
	assign dent  = dword[{col_q[1:0], 3'b0} +: 8];

	always_comb begin
		sb = 1'b0;
		sy = 1'b0;
		sm = 1'b0;
		sc = 1'b0;
		if (cfg.threshold != 4'd0) begin
			sb = bk_q > {4'd0, cfg.threshold ^ 4'hF};
		end else if (bk_q > dent) begin
			sb = 1'b1;
		end else if (cfg.color_mode) begin
			sy = ye_q > dent;
			sm = ma_q > dent;
			sc = cy_q > dent;
		end
	end

	assign status.out_free = !res_valid_q || !res_stall;
	assign status.last_rep = (rep_q == phtp_pkg::REP_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			pin_q       <= 6'd32;
			lane_q      <= '0;
			half_q      <= 1'b0;
			drow_q      <= '0;
			rep_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.load_row) begin
				half_q <= cfg.high_vres ? row_h[0] : 1'b0;
				drow_q <= row_h[1:0];
				col_q  <= start_column;
				rep_q  <= '0;
			end
			if (cmd.load_geom) begin
				pin_q  <= geom.pin;
				lane_q <= geom.lane;
			end
			if (cmd.load_pix)
				rep_q <= rep_in;
			if (cmd.emit) begin
				rep_q       <= rep_q - phtp_pkg::REP_W'(1);
				col_q       <= col_q + phtp_pkg::COL_W'(1);
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_row)
			row_q <= row_h;
		if (cmd.mul_row)
			quot_q <= prod[phtp_pkg::DIV24_SHIFT +: 12];
		if (cmd.load_pix) begin
			bk_q <= black;
			ye_q <= yellow;
			ma_q <= magenta;
			cy_q <= cyan;
		end
		if (cmd.emit) begin
			column_q   <= col_q;
			lane_out_q <= lane_q;
			mask_q     <= pin_q;
			half_out_q <= half_q;
			sb_q       <= sb;
			sy_q       <= sy;
			sm_q       <= sm;
			sc_q       <= sc;
			last_q     <= status.last_rep;
		end
	end

	assign res_valid   = res_valid_q;
	assign column      = column_q;
	assign byte_lane   = lane_out_q;
	assign bit_mask    = mask_q;
	assign second_half = half_out_q;
	assign set_black   = sb_q;
	assign set_yellow  = sy_q;
	assign set_magenta = sm_q;
	assign set_cyan    = sc_q;
	assign last_of_run = last_q;

	a_emit_has_rep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (rep_q != '0))
		else $error("column emitted with no repeats left");
	a_pin_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(pin_q))
		else $error("pin bit not one-hot");
	a_black_prio: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && sb_q) |-> !(sy_q || sm_q || sc_q))
		else $error("color plane set alongside black");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_stall) |-> !cmd.emit)
		else $error("pending result overwritten");

endmodule
`default_nettype wire

>>> rtl/core/print_head_halftone_packer_top.sv
// Top level of the print head halftone packer: config registers, sequencer, datapath.
// Row-start request: row registered, quotient in ST_ROW_MUL, pin and lane in ST_ROW_SET.
// Pixel request: pixel and repeat count registered on acceptance, then in ST_RUN one column
//   result per cycle is registered while the output is not stalled.
// The next request is taken while the final column result still waits at the output.
// Asynchronous reset clears config and control state: column 0, pin bit 32, lane 0.
`default_nettype none
module print_head_halftone_packer_top #(
	parameter int MAX_REPEAT = phtp_pkg::MAX_REPEAT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [phtp_pkg::CFG_AW-1:0]   paddr,
	input  wire logic [phtp_pkg::CFG_DW-1:0]   pwdata,
	output logic      [phtp_pkg::CFG_DW-1:0]   prdata,
	output logic                               pready,
	input  wire logic                          src_valid,
	output logic                               src_stall,
	input  wire logic                          action,
	input  wire logic [phtp_pkg::ROW_W-1:0]    row_number,
	input  wire logic [phtp_pkg::COL_W-1:0]    start_column,
	input  wire logic [7:0]                    black,
	input  wire logic [7:0]                    yellow,
	input  wire logic [7:0]                    magenta,
	input  wire logic [7:0]                    cyan,
	input  wire logic [phtp_pkg::REP_W-1:0]    repeat_req,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output logic      [phtp_pkg::COL_W-1:0]    column,
	output logic      [1:0]                    byte_lane,
	output logic      [5:0]                    bit_mask,
	output logic                               second_half,
	output logic                               set_black,
	output logic                               set_yellow,
	output logic                               set_magenta,
	output logic                               set_cyan,
	output logic                               last_of_run
);

	phtp_pkg::cfg_t       cfg;
	phtp_pkg::ctrl_cmd_t  cmd;
	phtp_pkg::dp_status_t status;

	phtp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	phtp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.action    (action),
		.src_stall (src_stall),
		.status    (status),
		.cmd       (cmd)
	);

	phtp_dp #(
		.MAX_REPEAT (MAX_REPEAT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.status       (status),
		.row_number   (row_number),
		.start_column (start_column),
		.black        (black),
		.yellow       (yellow),
		.magenta      (magenta),
		.cyan         (cyan),
		.repeat_req   (repeat_req),
		.res_stall    (res_stall),
		.res_valid    (res_valid),
		.column       (column),
		.byte_lane    (byte_lane),
		.bit_mask     (bit_mask),
		.second_half  (second_half),
		.set_black    (set_black),
		.set_yellow   (set_yellow),
		.set_magenta  (set_magenta),
		.set_cyan     (set_cyan),
		.last_of_run  (last_of_run)
	);

endmodule
`default_nettype wire

>>> sim/tb_print_head_halftone_packer_top.sv
// Testbench for the print head halftone packer: directed table plus random requests, self-checking.
`timescale 1ns / 100ps
module tb_print_head_halftone_packer_top;

	localparam logic ACT_ROW_START = 1'b0;
	localparam logic ACT_PIXEL     = 1'b1;
	localparam logic [4:0] REP_CAP = 5'((phtp_pkg::MAX_REPEAT_DEF < phtp_pkg::RESULT_CAP) ?
		phtp_pkg::MAX_REPEAT_DEF : phtp_pkg::RESULT_CAP);

	typedef struct packed {
		logic        act;
		logic [15:0] row;
		logic [15:0] scol;
		logic [7:0]  k;
		logic [7:0]  y;
		logic [7:0]  m;
		logic [7:0]  c;
		logic [4:0]  rep;
	} src_req_t;

	typedef struct packed {
		logic [15:0] column;
		logic [1:0]  lane;
		logic [5:0]  mask;
		logic        half;
		logic        blk;
		logic        yel;
		logic        mag;
		logic        cyn;
		logic        last;
	} col_result_t;

	typedef enum bit {STEP_WRITE, STEP_REQ} step_kind_t;

	typedef struct {
		step_kind_t          kind;
		phtp_pkg::reg_idx_t  idx;
		logic [31:0]         wval;
		src_req_t            r;
		bit                  typed;
		col_result_t         fixed;
	} dir_step_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [phtp_pkg::CFG_AW-1:0] paddr;
	logic [phtp_pkg::CFG_DW-1:0] pwdata;
	logic [phtp_pkg::CFG_DW-1:0] prdata;
	logic        pready;
	logic        src_valid;
	logic        src_stall;
	logic        action;
	logic [15:0] row_number;
	logic [15:0] start_column;
	logic [7:0]  black;
	logic [7:0]  yellow;
	logic [7:0]  magenta;
	logic [7:0]  cyan;
	logic [4:0]  repeat_req;
	logic        res_valid;
	logic        res_stall;
	logic [15:0] column;
	logic [1:0]  byte_lane;
	logic [5:0]  bit_mask;
	logic        second_half;
	logic        set_black;
	logic        set_yellow;
	logic        set_magenta;
	logic        set_cyan;
	logic        last_of_run;

	logic [3:0]  cfg_thresh;
	logic        cfg_color;
	logic        cfg_vres;
	logic [31:0] cfg_dither [4];

	logic [15:0] geo_col;
	logic [5:0]  geo_pin;
	logic [1:0]  geo_lane;
	logic        geo_half;
	logic [1:0]  geo_dsel;

	col_result_t pending_columns [$];
	int unsigned mismatches;
	bit          calm;

	print_head_halftone_packer_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.src_valid    (src_valid),
		.src_stall    (src_stall),
		.action       (action),
		.row_number   (row_number),
		.start_column (start_column),
		.black        (black),
		.yellow       (yellow),
		.magenta      (magenta),
		.cyan         (cyan),
		.repeat_req   (repeat_req),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.column       (column),
		.byte_lane    (byte_lane),
		.bit_mask     (bit_mask),
		.second_half  (second_half),
		.set_black    (set_black),
		.set_yellow   (set_yellow),
		.set_magenta  (set_magenta),
		.set_cyan     (set_cyan),
		.last_of_run  (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk) begin
		res_stall <= !calm && ($urandom_range(99) < 22);
	end

	// expected column results for one pixel request; a row-start request only updates the geometry
	task automatic halftone_request(input src_req_t r);
		logic [15:0] line;
		logic [4:0]  count;
		logic [7:0]  dith;
		col_result_t res;
		if (r.act == ACT_ROW_START) begin
			line     = cfg_vres ? (r.row >> 1) : r.row;
			geo_half = cfg_vres ? line[0] : 1'b0;
			geo_pin  = 6'd32 >> (line % 6);
			geo_lane = 2'((line % 24) / 6);
			geo_dsel = line[1:0];
			geo_col  = r.scol;
		end else begin
			count = (r.rep == 5'd0) ? 5'd1 : r.rep;
			if (count > REP_CAP)
				count = REP_CAP;
			while (count != 5'd0) begin
				res        = '0;
				res.column = geo_col;
				res.lane   = geo_lane;
				res.mask   = geo_pin;
				res.half   = geo_half;
				res.last   = (count == 5'd1);
				dith       = cfg_dither[geo_dsel][{geo_col[1:0], 3'b000} +: 8];
				if (cfg_thresh != 4'd0) begin
					res.blk = (r.k > (cfg_thresh ^ 4'hF));
				end else if (r.k > dith) begin
					res.blk = 1'b1;
				end else if (cfg_color) begin
					res.yel = (r.y > dith);
					res.mag = (r.m > dith);
					res.cyn = (r.c > dith);
				end
				pending_columns.push_back(res);
				geo_col = geo_col + 16'd1;
				count   = count - 5'd1;
			end
		end
	endtask

	task automatic send_request(input src_req_t r, input bit typed, input col_result_t fixed);
		if (!calm && $urandom_range(99) < 22) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		src_valid    <= 1'b1;
		action       <= r.act;
		row_number   <= r.row;
		start_column <= r.scol;
		black        <= r.k;
		yellow       <= r.y;
		magenta      <= r.m;
		cyan         <= r.c;
		repeat_req   <= r.rep;
		do @(posedge clk); while (src_stall);
		halftone_request(r);
		if (typed)
			pending_columns[pending_columns.size() - 1] = fixed;
	endtask

	task automatic write_reg(input phtp_pkg::reg_idx_t idx, input logic [31:0] v);
		src_valid <= 1'b0;
		while (pending_columns.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			phtp_pkg::REG_THRESHOLD:   cfg_thresh    = v[3:0];
			phtp_pkg::REG_COLOR_MODE:  cfg_color     = v[0];
			phtp_pkg::REG_HIGH_VRES:   cfg_vres      = v[0];
			phtp_pkg::REG_DITHER_ROW0: cfg_dither[0] = v;
			phtp_pkg::REG_DITHER_ROW1: cfg_dither[1] = v;
			phtp_pkg::REG_DITHER_ROW2: cfg_dither[2] = v;
			phtp_pkg::REG_DITHER_ROW3: cfg_dither[3] = v;
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_monitor
		col_result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_columns.size() == 0) begin
				$display("%0t: column result with none expected, column %0d", $time, column);
				mismatches++;
			end else begin
				want = pending_columns.pop_front();
				check_field("column", want.column, column);
				check_field("byte_lane", want.lane, byte_lane);
				check_field("bit_mask", want.mask, bit_mask);
				check_field("second_half", want.half, second_half);
				check_field("set_black", want.blk, set_black);
				check_field("set_yellow", want.yel, set_yellow);
				check_field("set_magenta", want.mag, set_magenta);
				check_field("set_cyan", want.cyn, set_cyan);
				check_field("last_of_run", want.last, last_of_run);
			end
		end
	end

	function automatic dir_step_t reg_step(input phtp_pkg::reg_idx_t idx, input logic [31:0] v);
		dir_step_t s;
		s       = '{kind: STEP_WRITE, idx: idx, wval: v, r: '0, typed: 1'b0, fixed: '0};
		return s;
	endfunction

	function automatic dir_step_t row_step(input logic [15:0] row, input logic [15:0] scol);
		dir_step_t s;
		s        = '{kind: STEP_REQ, idx: phtp_pkg::REG_THRESHOLD, wval: '0, r: '0,
			typed: 1'b0, fixed: '0};
		s.r.act  = ACT_ROW_START;
		s.r.row  = row;
		s.r.scol = scol;
		return s;
	endfunction

	function automatic dir_step_t pix_step(input logic [7:0] k, input logic [7:0] y,
			input logic [7:0] m, input logic [7:0] c, input logic [4:0] rep);
		dir_step_t s;
		s       = '{kind: STEP_REQ, idx: phtp_pkg::REG_THRESHOLD, wval: '0, r: '0,
			typed: 1'b0, fixed: '0};
		s.r.act = ACT_PIXEL;
		s.r.k   = k;
		s.r.y   = y;
		s.r.m   = m;
		s.r.c   = c;
		s.r.rep = rep;
		return s;
	endfunction

	function automatic dir_step_t pix_fixed(input logic [7:0] k, input logic [7:0] y,
			input logic [7:0] m, input logic [7:0] c, input logic [4:0] rep,
			input col_result_t want);
		dir_step_t s;
		s       = pix_step(k, y, m, c, rep);
		s.typed = 1'b1;
		s.fixed = want;
		return s;
	endfunction

	function automatic col_result_t col_res(input logic [15:0] col, input logic [1:0] lane,
			input logic [5:0] mask, input logic half, input logic [3:0] planes,
			input logic last);
		col_result_t res;
		res = {col, lane, mask, half, planes, last};
		return res;
	endfunction

	function automatic logic [31:0] dither_pick(input int p);
		logic [31:0] v;
		if (p == 4)
			v = 32'h0000_0000;
		else if (p == 5)
			v = 32'hFFFF_FFFF;
		else
			v = $urandom;
		return v;
	endfunction

	initial begin : stimulus
		dir_step_t   steps [$];
		src_req_t    r;
		int unsigned pick;
		arst_n       <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		src_valid    <= 1'b0;
		action       <= ACT_ROW_START;
		row_number   <= '0;
		start_column <= '0;
		black        <= '0;
		yellow       <= '0;
		magenta      <= '0;
		cyan         <= '0;
		repeat_req   <= '0;
		res_stall    <= 1'b0;
		mismatches   = 0;
		calm         = 1'b0;
		cfg_thresh   = '0;
		cfg_color    = 1'b0;
		cfg_vres     = 1'b0;
		cfg_dither   = '{default: '0};
		geo_col      = '0;
		geo_pin      = 6'd32;
		geo_lane     = '0;
		geo_half     = 1'b0;
		geo_dsel     = '0;

		// planes are {black, yellow, magenta, cyan}
		steps = '{
			pix_fixed(8'hFF, 8'h00, 8'h00, 8'h00, 5'd1,
				col_res(16'd0, 2'd0, 6'd32, 1'b0, 4'b1000, 1'b1)),
			pix_fixed(8'h00, 8'hFF, 8'hFF, 8'hFF, 5'd0,
				col_res(16'd1, 2'd0, 6'd32, 1'b0, 4'b0000, 1'b1)),
			pix_step(8'h80, 8'h7F, 8'h01, 8'hFE, 5'd31),
			row_step(16'hFFFF, 16'hFFFE),
			pix_step(8'h00, 8'hFF, 8'hFF, 8'hFF, 5'd4),
			reg_step(phtp_pkg::REG_DITHER_ROW0, 32'hFF80_4000),
			reg_step(phtp_pkg::REG_DITHER_ROW1, 32'hFFFF_FFFF),
			reg_step(phtp_pkg::REG_DITHER_ROW2, 32'h30A0_10C0),
			reg_step(phtp_pkg::REG_DITHER_ROW3, 32'h7F7F_7F7F),
			reg_step(phtp_pkg::REG_COLOR_MODE, 32'd1),
			row_step(16'd0, 16'd0),
			pix_step(8'h80, 8'h41, 8'h81, 8'hFF, 5'd4),
			row_step(16'd1, 16'd100),
			pix_fixed(8'hFF, 8'hFF, 8'hFF, 8'hFF, 5'd1,
				col_res(16'd100, 2'd0, 6'd16, 1'b0, 4'b0000, 1'b1)),
			row_step(16'd2, 16'hFFFF),
			pix_step(8'h00, 8'hFF, 8'h20, 8'hB0, 5'd5),
			reg_step(phtp_pkg::REG_HIGH_VRES, 32'd1),
			row_step(16'hFFFF, 16'd0),
			pix_fixed(8'h80, 8'h00, 8'h00, 8'h00, 5'd1,
				col_res(16'd0, 2'd1, 6'd16, 1'b1, 4'b1000, 1'b1)),
			pix_fixed(8'h7F, 8'h80, 8'h80, 8'h80, 5'd1,
				col_res(16'd1, 2'd1, 6'd16, 1'b1, 4'b0111, 1'b1)),
			reg_step(phtp_pkg::REG_THRESHOLD, 32'd15),
			pix_fixed(8'h01, 8'hFF, 8'hFF, 8'hFF, 5'd1,
				col_res(16'd2, 2'd1, 6'd16, 1'b1, 4'b1000, 1'b1)),
			reg_step(phtp_pkg::REG_THRESHOLD, 32'd1),
			pix_step(8'h0E, 8'hFF, 8'hFF, 8'hFF, 5'd2),
			pix_step(8'h0F, 8'h00, 8'h00, 8'h00, 5'd1),
			row_step(16'd47, 16'd9),
			pix_fixed(8'h0F, 8'h00, 8'h00, 8'h00, 5'd1,
				col_res(16'd9, 2'd3, 6'd1, 1'b1, 4'b1000, 1'b1))
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i]) begin
			if (steps[i].kind == STEP_WRITE)
				write_reg(steps[i].idx, steps[i].wval);
			else
				send_request(steps[i].r, steps[i].typed, steps[i].fixed);
		end

		for (int p = 0; p < 6; p++) begin
			write_reg(phtp_pkg::REG_THRESHOLD, (p == 1) ? 32'd15 :
				(p == 3) ? 32'($urandom_range(1, 14)) : 32'd0);
			write_reg(phtp_pkg::REG_COLOR_MODE, (p == 0) ? 32'd0 :
				(p == 2 || p == 4) ? 32'd1 : 32'($urandom_range(1)));
			write_reg(phtp_pkg::REG_HIGH_VRES, 32'($urandom_range(1)));
			write_reg(phtp_pkg::REG_DITHER_ROW0, dither_pick(p));
			write_reg(phtp_pkg::REG_DITHER_ROW1, dither_pick(p));
			write_reg(phtp_pkg::REG_DITHER_ROW2, dither_pick(p));
			write_reg(phtp_pkg::REG_DITHER_ROW3, dither_pick(p));
			calm = (p == 3);
			for (int n = 0; n < 27; n++) begin
				pick   = $urandom_range(99);
				r.act  = (n == 0 || pick < 15) ? ACT_ROW_START : ACT_PIXEL;
				r.row  = 16'($urandom);
				r.scol = ($urandom_range(3) == 0) ? 16'(16'hFFFF - $urandom_range(20)) :
					16'($urandom);
				r.k    = 8'($urandom);
				r.y    = 8'($urandom);
				r.m    = 8'($urandom);
				r.c    = 8'($urandom);
				pick   = $urandom_range(99);
				r.rep  = (pick < 70) ? 5'($urandom_range(3)) :
					(pick < 92) ? 5'($urandom_range(4, 16)) : 5'($urandom_range(17, 31));
				send_request(r, 1'b0, '0);
			end
			calm = 1'b0;
		end

		src_valid <= 1'b0;
		while (pending_columns.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
